@@ rtl/range_xor_update_range_sum_macros.svh @@
// Assertion macros for the range XOR / range sum block
`ifndef RANGE_XOR_UPDATE_RANGE_SUM_MACROS_SVH
`define RANGE_XOR_UPDATE_RANGE_SUM_MACROS_SVH
// implication checked at every clock outside reset
`define RXS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define RXS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/rxs_pkg.sv @@
// ----------------------------------------------------------------------------
// rxs_pkg
// Shared types and constants for the range XOR / range sum block.
// ----------------------------------------------------------------------------
`default_nettype none
package rxs_pkg;
    localparam int MAX_ELEMENTS = 1024;
    localparam int VALUE_BITS   = 22;
    localparam int IDX_W        = 11;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int SUM_W        = 32;

    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request, clip range
        logic clr_step; // clearing pass step
        logic acc;      // accumulate/writeback read data
        logic adv;      // advance address
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;    // clipped range empty
        logic last;     // current address is range end
        logic clr_last; // clearing pass at last entry
        logic is_upd;
    } t_sts;
endpackage
`default_nettype wire

@@ rtl/rxs_ram.sv @@
// ----------------------------------------------------------------------------
// rxs_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module rxs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/rxs_datapath.sv @@
// ----------------------------------------------------------------------------
// rxs_datapath
// Range clipping, element memory walk, XOR writeback and sum accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
module rxs_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rxs_pkg::t_cmd               i_cmd,
    input  wire logic                        i_cfg_we,
    input  wire logic [rxs_pkg::IDX_W-1:0]   i_cfg_len,
    input  wire logic                        i_opcode,
    input  wire logic [rxs_pkg::IDX_W-1:0]   i_range_low,
    input  wire logic [rxs_pkg::IDX_W-1:0]   i_range_high,
    input  wire logic [rxs_pkg::VALUE_BITS-1:0] i_xor_value,
    output rxs_pkg::t_sts                    o_sts,
    output logic [rxs_pkg::SUM_W-1:0]        o_sum
);
    import rxs_pkg::*;

    logic [IDX_W-1:0]      r_len;
    logic [IDX_W-1:0]      w_len_use, w_lo, w_hi;
    logic [ADDR_W-1:0]     r_addr, r_end, r_waddr;
    logic                  r_empty, r_upd, r_wb;
    logic [VALUE_BITS-1:0] r_xv, w_rdata, w_wdata;
    logic [SUM_W-1:0]      r_sum;
    logic                  w_we;

    assign w_len_use = (r_len > IDX_W'(MAX_ELEMENTS)) ? IDX_W'(MAX_ELEMENTS) : r_len;
    assign w_lo      = (i_range_low == '0) ? IDX_W'(1) : i_range_low;
    assign w_hi      = (i_range_high > w_len_use) ? w_len_use : i_range_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= IDX_W'(1024);
        end else if (i_cfg_we) begin
            r_len <= i_cfg_len;
        end
    end

    // writeback happens in the cycle after the read data lands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb <= 1'b0;
        end else begin
            r_wb <= i_cmd.acc && r_upd;
        end
        r_waddr <= r_addr;
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.load) begin
            r_addr <= ADDR_W'(w_lo - IDX_W'(1));
        end else if (i_cmd.clr_step || i_cmd.adv) begin
            r_addr <= r_addr + ADDR_W'(1);
        end
        if (i_cmd.load) begin
            r_empty <= (w_lo > w_hi);
            r_end   <= ADDR_W'(w_hi - IDX_W'(1));
            r_upd   <= (i_opcode == OP_UPDATE);
            r_xv    <= i_xor_value;
            r_sum   <= '0;
        end else if (i_cmd.acc && !r_upd) begin
            r_sum <= r_sum + SUM_W'(w_rdata);
        end
    end

    // read data XOR the update value for the address held during acc; keep r_addr steady then
    logic [VALUE_BITS-1:0] r_rd_hold;
    always_ff @(posedge i_clk) begin
        r_rd_hold <= w_rdata ^ r_xv;
    end

    assign w_we    = i_cmd.clr_step || r_wb;
    assign w_wdata = i_cmd.clr_step ? '0 : r_rd_hold;

    rxs_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ELEMENTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(i_cmd.clr_step ? r_addr : r_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_addr),
        .o_rdata(w_rdata)
    );

    assign o_sts.empty    = r_empty;
    assign o_sts.last     = (r_addr == r_end);
    assign o_sts.clr_last = (r_addr == ADDR_W'(MAX_ELEMENTS - 1));
    assign o_sts.is_upd   = r_upd;
    assign o_sum          = r_sum;
endmodule
`default_nettype wire

@@ rtl/rxs_ctrl.sv @@
// ----------------------------------------------------------------------------
// rxs_ctrl
// Sequencer: clearing pass, per-element read / accumulate / writeback.
// ----------------------------------------------------------------------------
`default_nettype none
module rxs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic               o_cfg_ready,
    input  wire rxs_pkg::t_sts i_sts,
    output rxs_pkg::t_cmd      o_cmd
);
    import rxs_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_READ  = 7'b0001000,
        S_ACC   = 7'b0010000,
        S_WB    = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.empty) begin
                    n_state = i_sts.is_upd ? S_IDLE : S_OUT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_WB;
            end
            S_WB: begin
                // for an update, writeback issued this cycle from registered data
                if (i_sts.last) begin
                    n_state = i_sts.is_upd ? S_IDLE : S_OUT;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = S_READ;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cfg_ready = (r_state == S_IDLE) || (r_state == S_CLEAR);
endmodule
`default_nettype wire

@@ rtl/range_xor_update_range_sum.sv @@
// ----------------------------------------------------------------------------
// range_xor_update_range_sum
// Range XOR update / range sum over a 1024 x 22-bit element memory.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// in        slave      i_in_valid/o_in_ready, opcode, range_low/high, xor_value
// out       master     o_out_valid/i_out_ready, range_sum
// cfg       slave      i_cfg_valid/o_cfg_ready, array_length
//
// For each element in the clipped range a request does one memory read,
// accumulate or XOR, and writeback, all through one RAM port pair.
// An empty range skips the walk; a query result then waits until taken.
// After reset a clearing pass zeroes all 1024 memory entries; no request
// is accepted during it, config writes are.
// ----------------------------------------------------------------------------
`default_nettype none
module range_xor_update_range_sum (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_opcode,
    input  wire logic [rxs_pkg::IDX_W-1:0]      i_range_low,
    input  wire logic [rxs_pkg::IDX_W-1:0]      i_range_high,
    input  wire logic [rxs_pkg::VALUE_BITS-1:0] i_xor_value,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [rxs_pkg::SUM_W-1:0]           o_range_sum,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [rxs_pkg::IDX_W-1:0]      i_array_length
);
    import rxs_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    rxs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_cfg_ready(o_cfg_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rxs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_len   (i_array_length),
        .i_opcode    (i_opcode),
        .i_range_low (i_range_low),
        .i_range_high(i_range_high),
        .i_xor_value (i_xor_value),
        .o_sts       (w_sts),
        .o_sum       (o_range_sum)
    );
endmodule
`default_nettype wire

@@ rtl/rxs_checker.sv @@
// ----------------------------------------------------------------------------
// rxs_checker
// Port-level assertions for the range XOR / range sum block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "range_xor_update_range_sum_macros.svh"
module rxs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_range_sum
);
    // no new request while a result is pending
    `RXS_ASSERT_IMP(a_busy_out, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    // result holds while stalled
    `RXS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_range_sum))
    // accepted request makes the block busy next cycle
    `RXS_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
endmodule

bind range_xor_update_range_sum rxs_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_range_sum(o_range_sum)
);
`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Range XOR / range sum testbench
// Drives query and update requests through the valid/ready channels, keeps
// a shadow copy of the element array, and checks every returned range sum in
// order against the shadow. Several array lengths are set between phases.
// ----------------------------------------------------------------------------
`default_nettype none

class sum_scoreboard;
    logic [rxs_pkg::VALUE_BITS-1:0] shadow_elems [rxs_pkg::MAX_ELEMENTS];
    logic [rxs_pkg::IDX_W-1:0]      shadow_len;
    logic [rxs_pkg::SUM_W-1:0]      pending_sums [$];
    int                             n_errors;
    int                             n_sums;
    int                             n_updates;

    function void clear();
        foreach (shadow_elems[i]) shadow_elems[i] = '0;
        shadow_len = 11'd1024;
        pending_sums.delete();
        n_errors = 0;
        n_sums = 0;
        n_updates = 0;
    endfunction

    // apply one accepted request to the shadow array
    function void note_request(logic op, logic [10:0] lo, logic [10:0] hi,
                               logic [rxs_pkg::VALUE_BITS-1:0] xv);
        int unsigned len;
        int unsigned a;
        int unsigned b;
        logic [63:0] acc;
        len = (shadow_len > rxs_pkg::MAX_ELEMENTS) ? rxs_pkg::MAX_ELEMENTS : shadow_len;
        a = (lo < 1) ? 1 : lo;
        b = (hi > len) ? len : hi;
        acc = '0;
        for (int unsigned i = a; i <= b; i++) begin
            if (op == rxs_pkg::OP_UPDATE) shadow_elems[i-1] ^= xv;
            else acc += shadow_elems[i-1];
        end
        if (op == rxs_pkg::OP_QUERY) pending_sums.push_back(acc[31:0]);
        else n_updates++;
    endfunction

    task check_sum(logic [rxs_pkg::SUM_W-1:0] got);
        logic [rxs_pkg::SUM_W-1:0] want;
        n_sums++;
        if (pending_sums.size() == 0) begin
            report_mismatch($sformatf("unexpected sum %0d", got));
            return;
        end
        want = pending_sums.pop_front();
        if (got !== want)
            report_mismatch($sformatf("range_sum got %0d want %0d", got, want));
    endtask

    task report_mismatch(string msg);
        $display("mismatch: %s", msg);
        n_errors++;
    endtask
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rxs_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_opcode = 1'b0;
    logic [IDX_W-1:0]      i_range_low = '0;
    logic [IDX_W-1:0]      i_range_high = '0;
    logic [VALUE_BITS-1:0] i_xor_value = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [SUM_W-1:0]      o_range_sum;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [IDX_W-1:0]      i_array_length = '0;

    sum_scoreboard sb;
    bit            calm;         // no idling in the final stretch
    int            stall_left;
    int            quiet_cycles;

    localparam int WATCHDOG = 20000;

    always #4 i_clk = ~i_clk;

    range_xor_update_range_sum u_top (.*);

    // sink: random stall bursts, checks every accepted sum
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_sum(o_range_sum);
            if (calm) begin
                i_out_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left  <= stall_left - 1;
                i_out_ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left  <= $urandom_range(0, 9);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog: cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("watchdog expired, %0d sums outstanding", sb.pending_sums.size());
            $display("FAIL range_xor_update_range_sum");
            $finish;
        end
    end

    // the block is busy at least through S_CHECK after a request, so the
    // one-cycle drop of valid after acceptance costs no throughput
    task automatic send_request(logic op, logic [10:0] lo, logic [10:0] hi,
                                logic [VALUE_BITS-1:0] xv);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_range_low  <= lo;
        i_range_high <= hi;
        i_xor_value  <= xv;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(op, lo, hi, xv);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait until idle, then write the length register
    task automatic set_length(logic [10:0] len);
        while (sb.pending_sums.size() != 0) @(posedge i_clk);
        repeat (3100) @(posedge i_clk);  // covers a full-length update still in flight
        i_cfg_valid    <= 1'b1;
        i_array_length <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.shadow_len = len;
        i_cfg_valid <= 1'b0;
    endtask

    // random request, mostly short ranges, some wide ones and edge indices
    task automatic random_request();
        logic [10:0] lo;
        logic [10:0] hi;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        lo = 11'($urandom_range(0, 1040));
        if (pick == 0) begin
            lo = 11'($urandom_range(0, 2047));
            hi = 11'($urandom_range(0, 2047));
        end else if (pick == 1) begin
            lo = 11'($urandom_range(0, 2));
            hi = 11'($urandom_range(1000, 2047));
        end else if (pick == 2) begin
            hi = lo - 11'($urandom_range(1, 5));
        end else begin
            hi = lo + 11'($urandom_range(0, 24));
        end
        send_request(1'($urandom_range(0, 1)), lo, hi, VALUE_BITS'($urandom));
    endtask

    initial begin
        sb = new();
        sb.clear();
        calm = 1'b0;
        stall_left = 0;
        quiet_cycles = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: edges of the fields and the clipping cases
        send_request(OP_QUERY, 11'd1, 11'd1024, '0);
        send_request(OP_UPDATE, 11'd1, 11'd1024, 22'h3FFFFF);
        send_request(OP_QUERY, 11'd1, 11'd1024, '0);
        send_request(OP_UPDATE, 11'd0, 11'd3, 22'h155555);   // low index zero
        send_request(OP_UPDATE, 11'd1020, 11'd2047, 22'h2AAAAA); // high clipped
        send_request(OP_QUERY, 11'd0, 11'd2047, 22'h3FFFFF);
        send_request(OP_QUERY, 11'd1024, 11'd1024, '0);
        send_request(OP_QUERY, 11'd10, 11'd9, '0);            // reversed
        send_request(OP_UPDATE, 11'd10, 11'd9, 22'h1);
        send_request(OP_QUERY, 11'd2047, 11'd2047, '0);
        send_request(OP_UPDATE, 11'd5, 11'd5, 22'h000001);
        send_request(OP_QUERY, 11'd4, 11'd6, '0);

        set_length(11'd0);                                    // length zero
        send_request(OP_UPDATE, 11'd1, 11'd5, 22'h3FFFFF);
        send_request(OP_QUERY, 11'd0, 11'd2047, '0);
        set_length(11'd2047);                                 // too large
        send_request(OP_QUERY, 11'd1, 11'd2047, '0);
        set_length(11'd1);
        send_request(OP_QUERY, 11'd1, 11'd1, '0);
        send_request(OP_UPDATE, 11'd0, 11'd2, 22'h0F0F0F);
        set_length(11'd1024);                                 // shrunk tail returns
        send_request(OP_QUERY, 11'd1, 11'd1024, '0);

        // random phases over several lengths; stress the short ones most
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_length(11'd16);
                1: set_length(11'd1024);
                2: set_length(11'd100);
                3: set_length(11'd1);
                4: set_length(11'd1500);
                default: set_length(11'd40);
            endcase
            if (ph == 5) calm = 1'b1;
            repeat (215) random_request();
        end

        while (sb.pending_sums.size() != 0) @(posedge i_clk);
        repeat (3200) @(posedge i_clk);
        $display("covered %0d updates and %0d returned sums over several array lengths",
                 sb.n_updates, sb.n_sums);
        if (sb.n_errors == 0 && sb.pending_sums.size() == 0) begin
            $display("PASS range_xor_update_range_sum");
        end else begin
            $display("FAIL range_xor_update_range_sum");
        end
        $finish;
    end
endmodule

`default_nettype wire
